// ===== sv/cp437_html_entity_escaper_macros.svh =====
// Assertion helpers for the escaper
`ifndef CP437_HTML_ENTITY_ESCAPER_MACROS_SVH
`define CP437_HTML_ENTITY_ESCAPER_MACROS_SVH

// Check that a condition implies a consequence on the same edge
`define CHE_ASSERT_IMPL(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (conseq)) else $error(msg);

// Check that a condition implies a consequence on the next edge
`define CHE_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (conseq)) else $error(msg);

`endif

// ===== sv/che_pkg.sv =====
package che_pkg;

    // One encoded character group
    typedef struct packed {
        logic [63:0] chars;
        logic [3:0]  len;
    } chunk_t;

    // Context for the byte being encoded
    typedef struct packed {
        logic [7:0] b;
        logic       first;
        logic [7:0] prev;
        logic       has_next;
        logic [7:0] next;
        logic       text;
    } enc_ctx_t;

    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_DEL  = 8'h7F;

    // Unicode point of a CP437 byte, zero when the byte passes through
    function automatic logic [15:0] cp_point(input logic [7:0] b);
        logic [15:0] p;
        p = 16'h0000;
        if (b[7]) begin
            unique case (b[6:0])
                7'd0: p = 16'h00C7;   7'd1: p = 16'h00FC;   7'd2: p = 16'h00E9;
                7'd3: p = 16'h00E2;   7'd4: p = 16'h00E4;   7'd5: p = 16'h00E0;
                7'd6: p = 16'h00E5;   7'd7: p = 16'h00E7;   7'd8: p = 16'h00EA;
                7'd9: p = 16'h00EB;   7'd10: p = 16'h00E8;  7'd11: p = 16'h00EF;
                7'd12: p = 16'h00EE;  7'd13: p = 16'h00EC;  7'd14: p = 16'h00C4;
                7'd15: p = 16'h00C5;  7'd16: p = 16'h00C9;  7'd17: p = 16'h00E6;
                7'd18: p = 16'h00C6;  7'd19: p = 16'h00F4;  7'd20: p = 16'h00F6;
                7'd21: p = 16'h00F2;  7'd22: p = 16'h00FB;  7'd23: p = 16'h00F9;
                7'd24: p = 16'h00FF;  7'd25: p = 16'h00D6;  7'd26: p = 16'h00DC;
                7'd27: p = 16'h00A2;  7'd28: p = 16'h00A3;  7'd29: p = 16'h00A5;
                7'd30: p = 16'h20A7;  7'd31: p = 16'h0192;  7'd32: p = 16'h00E1;
                7'd33: p = 16'h00ED;  7'd34: p = 16'h00F3;  7'd35: p = 16'h00FA;
                7'd36: p = 16'h00F1;  7'd37: p = 16'h00D1;  7'd38: p = 16'h00AA;
                7'd39: p = 16'h00BA;  7'd40: p = 16'h00BF;  7'd41: p = 16'h2310;
                7'd42: p = 16'h00AC;  7'd43: p = 16'h00BD;  7'd44: p = 16'h00BC;
                7'd45: p = 16'h00A1;  7'd46: p = 16'h00AB;  7'd47: p = 16'h00BB;
                7'd48: p = 16'h2591;  7'd49: p = 16'h2592;  7'd50: p = 16'h2593;
                7'd51: p = 16'h2502;  7'd52: p = 16'h2524;  7'd53: p = 16'h2561;
                7'd54: p = 16'h2562;  7'd55: p = 16'h2556;  7'd56: p = 16'h2555;
                7'd57: p = 16'h2563;  7'd58: p = 16'h2551;  7'd59: p = 16'h2557;
                7'd60: p = 16'h255D;  7'd61: p = 16'h255C;  7'd62: p = 16'h255B;
                7'd63: p = 16'h2510;  7'd64: p = 16'h2514;  7'd65: p = 16'h2534;
                7'd66: p = 16'h252C;  7'd67: p = 16'h251C;  7'd68: p = 16'h2500;
                7'd69: p = 16'h253C;  7'd70: p = 16'h255E;  7'd71: p = 16'h255F;
                7'd72: p = 16'h255A;  7'd73: p = 16'h2554;  7'd74: p = 16'h2569;
                7'd75: p = 16'h2566;  7'd76: p = 16'h2560;  7'd77: p = 16'h2550;
                7'd78: p = 16'h256C;  7'd79: p = 16'h2567;  7'd80: p = 16'h2568;
                7'd81: p = 16'h2564;  7'd82: p = 16'h2565;  7'd83: p = 16'h2559;
                7'd84: p = 16'h2558;  7'd85: p = 16'h2552;  7'd86: p = 16'h2553;
                7'd87: p = 16'h256B;  7'd88: p = 16'h256A;  7'd89: p = 16'h2518;
                7'd90: p = 16'h250C;  7'd91: p = 16'h2588;  7'd92: p = 16'h2584;
                7'd93: p = 16'h258C;  7'd94: p = 16'h2590;  7'd95: p = 16'h2580;
                7'd96: p = 16'h03B1;  7'd97: p = 16'h03B2;  7'd98: p = 16'h0393;
                7'd99: p = 16'h03C0;  7'd100: p = 16'h03A3; 7'd101: p = 16'h03C3;
                7'd102: p = 16'h00B5; 7'd103: p = 16'h03C4; 7'd104: p = 16'h03A6;
                7'd105: p = 16'h0398; 7'd106: p = 16'h03A9; 7'd107: p = 16'h03B4;
                7'd108: p = 16'h221E; 7'd109: p = 16'h2205; 7'd110: p = 16'h2208;
                7'd111: p = 16'h2229; 7'd112: p = 16'h2261; 7'd113: p = 16'h00B1;
                7'd114: p = 16'h2265; 7'd115: p = 16'h2264; 7'd116: p = 16'h2320;
                7'd117: p = 16'h2321; 7'd118: p = 16'h00F7; 7'd119: p = 16'h2248;
                7'd120: p = 16'h00B0; 7'd121: p = 16'h2219; 7'd122: p = 16'h00B7;
                7'd123: p = 16'h221A; 7'd124: p = 16'h207F; 7'd125: p = 16'h00B2;
                7'd126: p = 16'h25AA; default: p = 16'h0000;
            endcase
        end else if (b == CH_DEL) begin
            p = 16'h2302;
        end else if (b[7:5] == 3'b000) begin
            unique case (b[4:0])
                5'd1: p = 16'h263A;  5'd2: p = 16'h263B;  5'd3: p = 16'h2665;
                5'd4: p = 16'h2666;  5'd5: p = 16'h2663;  5'd6: p = 16'h2660;
                5'd7: p = 16'h2022;  5'd8: p = 16'h25D8;  5'd9: p = 16'h25CB;
                5'd11: p = 16'h2642; 5'd12: p = 16'h2640; 5'd14: p = 16'h266B;
                5'd15: p = 16'h263C; 5'd16: p = 16'h25B8; 5'd17: p = 16'h25C2;
                5'd18: p = 16'h2195; 5'd19: p = 16'h203C; 5'd20: p = 16'h00B6;
                5'd21: p = 16'h00A7; 5'd22: p = 16'h25AC; 5'd23: p = 16'h21A8;
                5'd24: p = 16'h2191; 5'd25: p = 16'h2193; 5'd26: p = 16'h2192;
                5'd27: p = 16'h2190; 5'd28: p = 16'h221F; 5'd29: p = 16'h2194;
                5'd30: p = 16'h25B4; 5'd31: p = 16'h25BE;
                default: p = 16'h0000;
            endcase
        end
        return p;
    endfunction

    // Uppercase hex character of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
    endfunction

endpackage

// ===== sv/cp437_html_entity_escaper.sv =====
// CP437 to HTML escaper. Takes one string byte per cycle while s_ready is high
// and returns packed chunks of one to eight characters; one byte is held back so
// a space can see its successor. Each transfer yields one chunk for the held byte,
// if one is held, and, on the end-of-string byte, a second chunk for that byte, so
// a string of N bytes yields N chunks. Results go through a two-entry output queue;
// input is taken whenever that queue has room for two chunks or is drained in the
// same cycle.
`include "cp437_html_entity_escaper_macros.svh"
module cp437_html_entity_escaper (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_text_mode,
    input  logic        s_end_of_string,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_chunk_chars,
    output logic [3:0]  m_chunk_length,
    output logic        m_last_chunk
);

    logic [7:0] held_byte_reg;
    logic       held_valid_reg;
    logic [7:0] before_held_reg;
    logic       held_first_reg;
    logic       held_text_reg;

    // Output queue, two entries
    logic [63:0] q_chars_reg [2];
    logic [3:0]  q_len_reg   [2];
    logic        q_last_reg  [2];
    logic [1:0]  q_cnt_reg, q_cnt_next;

    che_pkg::enc_ctx_t ctx_a, ctx_b;
    che_pkg::chunk_t   ch_a, ch_b;
    logic              acc, pop;
    logic [1:0]        n_new, base;

    assign pop     = m_valid && m_ready;
    assign s_ready = (q_cnt_reg == 2'd0) || (q_cnt_reg == 2'd1 && m_ready);
    assign acc     = s_valid && s_ready;

    // Held byte judged against the incoming byte
    always_comb begin
        ctx_a.b        = held_byte_reg;
        ctx_a.first    = held_first_reg;
        ctx_a.prev     = held_first_reg ? 8'h0 : before_held_reg;
        ctx_a.has_next = 1'b1;
        ctx_a.next     = s_in_byte;
        ctx_a.text     = held_text_reg;
        ctx_b.b        = s_in_byte;
        ctx_b.first    = !held_valid_reg;
        ctx_b.prev     = held_valid_reg ? held_byte_reg : 8'h0;
        ctx_b.has_next = 1'b0;
        ctx_b.next     = 8'h0;
        ctx_b.text     = s_text_mode;
    end

    che_encoder u_enc_a (.ctx(ctx_a), .chunk(ch_a));
    che_encoder u_enc_b (.ctx(ctx_b), .chunk(ch_b));

    assign n_new      = acc ? ({1'b0, held_valid_reg} + {1'b0, s_end_of_string}) : 2'd0;
    assign base       = q_cnt_reg - {1'b0, pop};
    assign q_cnt_next = base + n_new;

    // Advance hold state and queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_byte_reg  <= 8'h0;
            before_held_reg <= 8'h0;
            held_first_reg <= 1'b0;
            held_text_reg  <= 1'b0;
            q_cnt_reg      <= 2'd0;
        end else begin
            q_cnt_reg <= q_cnt_next;
            if (pop && q_cnt_reg == 2'd2) begin
                q_chars_reg[0] <= q_chars_reg[1];
                q_len_reg[0]   <= q_len_reg[1];
                q_last_reg[0]  <= q_last_reg[1];
            end
            if (acc) begin
                if (held_valid_reg) begin
                    q_chars_reg[base[0]] <= ch_a.chars;
                    q_len_reg[base[0]]   <= ch_a.len;
                    q_last_reg[base[0]]  <= 1'b0;
                end
                if (s_end_of_string) begin
                    q_chars_reg[base[0] ^ held_valid_reg] <= ch_b.chars;
                    q_len_reg[base[0] ^ held_valid_reg]   <= ch_b.len;
                    q_last_reg[base[0] ^ held_valid_reg]  <= 1'b1;
                    held_valid_reg  <= 1'b0;
                    held_byte_reg   <= 8'h0;
                    before_held_reg <= 8'h0;
                    held_first_reg  <= 1'b0;
                    held_text_reg   <= 1'b0;
                end else begin
                    held_valid_reg  <= 1'b1;
                    held_byte_reg   <= s_in_byte;
                    before_held_reg <= ctx_b.prev;
                    held_first_reg  <= ctx_b.first;
                    held_text_reg   <= s_text_mode;
                end
            end
        end
    end

    assign m_valid        = q_cnt_reg != 2'd0;
    assign m_chunk_chars  = q_chars_reg[0];
    assign m_chunk_length = q_len_reg[0];
    assign m_last_chunk   = q_last_reg[0];

    `CHE_ASSERT_IMPL(a_cnt_range, 1'b1, q_cnt_reg != 2'd3, "queue overflow")
    `CHE_ASSERT_NEXT(a_eos_clears, acc && s_end_of_string, !held_valid_reg,
        "hold not cleared at end of string")
    `CHE_ASSERT_IMPL(a_len_range, m_valid, m_chunk_length != 4'd0 && m_chunk_length <= 4'd8,
        "bad chunk length")

endmodule

// ===== sv/che_encoder.sv =====
module che_encoder (
    input  che_pkg::enc_ctx_t ctx,
    output che_pkg::chunk_t   chunk
);

    logic [15:0] point;
    logic        nbsp;

    assign point = che_pkg::cp_point(ctx.b);
    assign nbsp  = ctx.text && ((ctx.has_next && ctx.next == che_pkg::CH_SP) || ctx.first
                   || ctx.prev == che_pkg::CH_SP || ctx.prev == che_pkg::CH_NL);

    // Pick the entity text or the plain byte
    always_comb begin
        chunk.chars = 64'h0;
        chunk.len   = 4'd1;
        if (ctx.b == che_pkg::CH_QUOT) begin
            chunk.chars = 64'h0000_3B74_6F75_7126;
            chunk.len   = 4'd6;
        end else if (ctx.b == che_pkg::CH_AMP) begin
            chunk.chars = 64'h0000_003B_706D_6126;
            chunk.len   = 4'd5;
        end else if (ctx.b == che_pkg::CH_LT) begin
            chunk.chars = 64'h0000_0000_3B74_6C26;
            chunk.len   = 4'd4;
        end else if (ctx.b == che_pkg::CH_GT) begin
            chunk.chars = 64'h0000_0000_3B74_6726;
            chunk.len   = 4'd4;
        end else if (ctx.b == che_pkg::CH_SP) begin
            if (nbsp) begin
                chunk.chars = 64'h0000_3B70_7362_6E26;
                chunk.len   = 4'd6;
            end else begin
                chunk.chars = {56'h0, che_pkg::CH_SP};
            end
        end else if (point != 16'h0) begin
            chunk.chars = {8'h3B, che_pkg::hex_char(point[3:0]),
                           che_pkg::hex_char(point[7:4]), che_pkg::hex_char(point[11:8]),
                           che_pkg::hex_char(point[15:12]), 24'h78_2326};
            chunk.len   = 4'd8;
        end else begin
            chunk.chars = {56'h0, ctx.b};
        end
    end

endmodule

// ===== bench/tb_cp437_html_entity_escaper.sv =====
module tb_cp437_html_entity_escaper;

    typedef struct {
        logic [63:0] chars;
        logic [3:0]  len;
        logic        last;
    } chunk_exp_t;

    // Escaping predictor and queue of chunks still owed by the block
    class escape_scoreboard;
        logic [7:0] held_byte;
        logic       held_valid;
        logic [7:0] prev_of_held;
        logic       held_first;
        logic       held_text;
        chunk_exp_t pending[$];
        int         errors;
        int         chunks_checked;

        function void clear();
            held_byte = 8'h00;
            held_valid = 1'b0;
            prev_of_held = 8'h00;
            held_first = 1'b0;
            held_text = 1'b0;
            errors = 0;
            chunks_checked = 0;
        endfunction

        function logic [15:0] unicode_of(logic [7:0] b);
            logic [15:0] lo[32];
            logic [15:0] hi[128];
            lo = '{16'h0000, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660,
                   16'h2022, 16'h25D8, 16'h25CB, 16'h0000, 16'h2642, 16'h2640, 16'h0000,
                   16'h266B, 16'h263C, 16'h25B8, 16'h25C2, 16'h2195, 16'h203C, 16'h00B6,
                   16'h00A7, 16'h25AC, 16'h21A8, 16'h2191, 16'h2193, 16'h2192, 16'h2190,
                   16'h221F, 16'h2194, 16'h25B4, 16'h25BE};
            hi = '{16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5,
                   16'h00E7, 16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC,
                   16'h00C4, 16'h00C5, 16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6,
                   16'h00F2, 16'h00FB, 16'h00F9, 16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2,
                   16'h00A3, 16'h00A5, 16'h20A7, 16'h0192, 16'h00E1, 16'h00ED, 16'h00F3,
                   16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA, 16'h00BF, 16'h2310,
                   16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB, 16'h2591,
                   16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
                   16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B,
                   16'h2510, 16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C,
                   16'h255E, 16'h255F, 16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560,
                   16'h2550, 16'h256C, 16'h2567, 16'h2568, 16'h2564, 16'h2565, 16'h2559,
                   16'h2558, 16'h2552, 16'h2553, 16'h256B, 16'h256A, 16'h2518, 16'h250C,
                   16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580, 16'h03B1, 16'h03B2,
                   16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4, 16'h03A6,
                   16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h2205, 16'h2208, 16'h2229,
                   16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7,
                   16'h2248, 16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2,
                   16'h25AA, 16'h0000};
            if (b < 8'd32) return lo[b[4:0]];
            if (b == che_pkg::CH_DEL) return 16'h2302;
            if (b[7]) return hi[b[6:0]];
            return 16'h0000;
        endfunction

        function chunk_exp_t pack_str(string s, logic last);
            chunk_exp_t c;
            c.chars = '0;
            for (int i = 0; i < s.len(); i++) c.chars[8*i +: 8] = s[i];
            c.len = 4'(s.len());
            c.last = last;
            return c;
        endfunction

        function chunk_exp_t escape_byte(logic [7:0] b, logic first, logic [7:0] prev,
                                         logic has_next, logic [7:0] nxt, logic text,
                                         logic last);
            chunk_exp_t c;
            logic [15:0] pt;
            logic [3:0] nib;
            case (b)
                che_pkg::CH_QUOT: return pack_str("&quot;", last);
                che_pkg::CH_AMP:  return pack_str("&amp;", last);
                che_pkg::CH_LT:   return pack_str("&lt;", last);
                che_pkg::CH_GT:   return pack_str("&gt;", last);
                che_pkg::CH_SP: begin
                    if (text && ((has_next && nxt == che_pkg::CH_SP) || first ||
                                 prev == che_pkg::CH_SP || prev == che_pkg::CH_NL))
                        return pack_str("&nbsp;", last);
                    return pack_str(" ", last);
                end
                default: ;
            endcase
            pt = unicode_of(b);
            c.last = last;
            if (pt == 16'h0000) begin
                c.chars = {56'h0, b};
                c.len = 4'd1;
                return c;
            end
            c.chars = '0;
            c.chars[7:0] = "&";
            c.chars[15:8] = "#";
            c.chars[23:16] = "x";
            for (int i = 0; i < 4; i++) begin
                nib = pt[12 - 4*i +: 4];
                c.chars[8*(3+i) +: 8] = (nib < 4'd10) ? 8'h30 + {4'h0, nib}
                                                      : 8'h37 + {4'h0, nib};
            end
            c.chars[63:56] = ";";
            c.len = 4'd8;
            return c;
        endfunction

        // Note an accepted byte: release the held byte and maybe the new one
        function void note_byte(logic [7:0] b, logic text, logic eos);
            logic first;
            logic [7:0] prev;
            first = 1'b1;
            prev = 8'h00;
            if (held_valid) begin
                pending.push_back(escape_byte(held_byte, held_first,
                    held_first ? 8'h00 : prev_of_held, 1'b1, b, held_text, 1'b0));
                first = 1'b0;
                prev = held_byte;
            end
            if (eos) begin
                pending.push_back(escape_byte(b, first, prev, 1'b0, 8'h00, text, 1'b1));
                held_valid = 1'b0;
                held_byte = 8'h00;
                prev_of_held = 8'h00;
                held_first = 1'b0;
                held_text = 1'b0;
            end else begin
                held_valid = 1'b1;
                held_byte = b;
                prev_of_held = prev;
                held_first = first;
                held_text = text;
            end
        endfunction

        function void check_chunk(logic [63:0] chars, logic [3:0] len, logic last);
            chunk_exp_t e;
            if (pending.size() == 0) begin
                $error("unexpected chunk chars=%h length=%0d", chars, len);
                errors++;
                return;
            end
            e = pending.pop_front();
            chunks_checked++;
            if (chars !== e.chars) begin
                $error("chunk_chars expected %h actual %h", e.chars, chars);
                errors++;
            end
            if (len !== e.len) begin
                $error("chunk_length expected %0d actual %0d", e.len, len);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_chunk expected %0b actual %0b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_text_mode;
    logic        s_end_of_string;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_chunk_chars;
    logic [3:0]  m_chunk_length;
    logic        m_last_chunk;

    escape_scoreboard escapes;
    int  bytes_sent;
    int  strings_sent;
    int  idle_cycles;
    bit  timed_out;
    bit  hold_off;

    localparam int WATCHDOG_LIMIT = 2000;

    cp437_html_entity_escaper dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_text_mode    (s_text_mode),
        .s_end_of_string(s_end_of_string),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chunk_chars  (m_chunk_chars),
        .m_chunk_length (m_chunk_length),
        .m_last_chunk   (m_last_chunk)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Offer one byte after a random gap, hold it until the transfer
    task automatic send_byte(logic [7:0] b, logic text, logic eos);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        s_text_mode <= text;
        s_end_of_string <= eos;
        do @(posedge aclk); while (!s_ready);
        escapes.note_byte(b, text, eos);
        bytes_sent++;
        if (eos) strings_sent++;
    endtask

    task automatic send_string(logic [7:0] bytes[$], logic text);
        foreach (bytes[i]) send_byte(bytes[i], text, i == bytes.size() - 1);
    endtask

    // Draw a byte biased toward the interesting ones
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return che_pkg::CH_SP;
            3: return che_pkg::CH_NL;
            4: begin
                case ($urandom_range(0, 3))
                    0: return che_pkg::CH_QUOT;
                    1: return che_pkg::CH_AMP;
                    2: return che_pkg::CH_LT;
                    default: return che_pkg::CH_GT;
                endcase
            end
            5: return 8'($urandom_range(128, 255));
            6: return 8'($urandom_range(1, 31));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Receiver: random stall per chunk, except during the long hold-off
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Check every chunk transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            escapes.check_chunk(m_chunk_chars, m_chunk_length, m_last_chunk);
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [7:0] str[$];
        int len;
        logic text;
        escapes = new();
        escapes.clear();
        bytes_sent = 0;
        strings_sent = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        hold_off = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_byte = 8'h00;
        s_text_mode = 1'b0;
        s_end_of_string = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: leading space, space runs, space after newline, entities
        str = '{che_pkg::CH_SP, 8'h41, che_pkg::CH_SP, che_pkg::CH_SP, 8'h42,
                che_pkg::CH_NL, che_pkg::CH_SP, 8'h43, che_pkg::CH_SP};
        send_string(str, 1'b1);
        str = '{che_pkg::CH_SP, che_pkg::CH_QUOT, che_pkg::CH_AMP, che_pkg::CH_LT,
                che_pkg::CH_GT, che_pkg::CH_SP, che_pkg::CH_SP};
        send_string(str, 1'b0);
        // Extremes: byte 1, 127, 128, 0xD4, 254, 255, and one-byte strings
        str = '{8'h01, 8'h7F, 8'h80, 8'hD4, 8'hFE, 8'hFF, 8'h0D};
        send_string(str, 1'b1);
        send_byte(che_pkg::CH_SP, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        // Mode switch inside one string
        send_byte(che_pkg::CH_SP, 1'b0, 1'b0);
        send_byte(che_pkg::CH_SP, 1'b1, 1'b0);
        send_byte(che_pkg::CH_SP, 1'b0, 1'b1);

        // Long receiver hold-off while bytes keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 12; i++)
                    send_byte(pick_byte(), 1'b1, i == 11);
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        join

        // Random strings; some bytes get a random mode and a full-range value
        while (bytes_sent < 830) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            text = 1'($urandom_range(0, 1));
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 7) == 0)
                    send_byte(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)),
                              i == len - 1);
                else
                    send_byte(pick_byte(), text, i == len - 1);
            end
        end
        s_valid <= 1'b0;

        while (escapes.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("Sent %0d bytes in %0d strings, checked %0d chunks.",
                 bytes_sent, strings_sent, escapes.chunks_checked);
        $display("Covered entities, hex escapes, space rules, mode switches and stalls.");
        if (escapes.errors == 0 && escapes.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
